// ----- sv/cip_pkg.sv -----
// shared types and constants for the css input preprocessor
`default_nettype none
package cip_pkg;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_NUL,
		OP_FAULT
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
		logic       fin;
	} q_entry_t;

	typedef enum logic [1:0] {
		IDX_FIRST,
		IDX_SECOND,
		IDX_THIRD
	} sub_idx_t;

endpackage
`default_nettype wire

// ----- sv/cip_if.sv -----
// valid/ready channel interfaces for raw input bytes and preprocessed output bytes
`default_nettype none
interface cip_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       final_byte;

	modport source(output valid, in_byte, final_byte, input ready);
	modport sink(input valid, in_byte, final_byte, output ready);
endinterface

interface cip_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       corrupt;
	logic       stream_end;

	modport source(output valid, out_byte, run_last, corrupt, stream_end, input ready);
	modport sink(input valid, out_byte, run_last, corrupt, stream_end, output ready);
endinterface
`default_nettype wire

// ----- sv/cip_front.sv -----
// front end: accepts raw bytes, tracks cr and utf-8 state, classifies into queue entries
`default_nettype none
module cip_front import cip_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	cip_in_if.sink    din,
	input  wire logic q_ready,
	output logic      q_push,
	output q_entry_t  q_entry
);

	logic       cr_pending_q;
	logic [2:0] cont_left_q;
	logic       failed_q;

	logic       cr_pending_d;
	logic [2:0] cont_left_d;
	logic       failed_d;
	logic       emit;
	logic       accept;
	logic [3:0] ones;
	logic [3:0] ones_m1;
	logic [7:0] b;
	logic       fin;

	function automatic logic [3:0] lead_ones(input logic [7:0] v);
		logic [3:0] n;
		logic       run;
		n = 4'd0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			if (run && v[i]) begin
				n = n + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
		return n;
	endfunction

	assign b = din.in_byte;
	assign fin = din.final_byte;
	assign din.ready = q_ready;
	assign accept = din.valid && q_ready;
	assign q_push = accept && emit;
	assign ones = lead_ones(b);
	assign ones_m1 = ones - 4'd1;

	always_comb begin
		cr_pending_d = cr_pending_q;
		cont_left_d = cont_left_q;
		failed_d = failed_q;
		emit = 1'b1;
		q_entry.kind = OP_BYTE;
		q_entry.data = b;
		q_entry.fin = fin;
		if (failed_q) begin
			// silent until the stream ends
			emit = fin;
			q_entry.kind = OP_FAULT;
		end else if (cont_left_q != 3'd0) begin
			cr_pending_d = 1'b0;
			if (b[7:6] != 2'b10 || (fin && cont_left_q > 3'd1)) begin
				q_entry.kind = OP_FAULT;
				failed_d = 1'b1;
			end else begin
				cont_left_d = cont_left_q - 3'd1;
			end
		end else if (b[7]) begin
			cr_pending_d = 1'b0;
			if (ones == 4'd1 || fin) begin
				q_entry.kind = OP_FAULT;
				failed_d = 1'b1;
			end else begin
				// eight leading ones gives seven continuations
				cont_left_d = ones_m1[2:0];
			end
		end else if (b == CH_NUL) begin
			cr_pending_d = 1'b0;
			q_entry.kind = OP_NUL;
		end else if (b == CH_CR) begin
			cr_pending_d = 1'b1;
			q_entry.data = CH_LF;
		end else if (b == CH_LF && cr_pending_q) begin
			cr_pending_d = 1'b0;
			emit = 1'b0;
		end else begin
			cr_pending_d = 1'b0;
			if (b == CH_FF) begin
				q_entry.data = CH_LF;
			end
		end
		if (fin) begin
			cr_pending_d = 1'b0;
			cont_left_d = 3'd0;
			failed_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_pending_q <= 1'b0;
			cont_left_q <= 3'd0;
			failed_q <= 1'b0;
		end else if (accept) begin
			cr_pending_q <= cr_pending_d;
			cont_left_q <= cont_left_d;
			failed_q <= failed_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/cip_queue.sv -----
// short register queue between the front and back ends
`default_nettype none
module cip_queue import cip_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  q_entry_t      wr_entry,
	output logic          wr_ready,
	input  wire logic     pop,
	output logic          rd_valid,
	output q_entry_t      rd_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	q_entry_t       mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign wr_ready = count_q != FULL_CNT;
	assign rd_valid = count_q != '0;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("queue count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count lost a push");

endmodule
`default_nettype wire

// ----- sv/cip_back.sv -----
// back end: expands queue entries into output beats behind an output register
`default_nettype none
module cip_back import cip_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  q_entry_t  q_entry,
	output logic      q_pop,
	cip_out_if.source dout
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       corrupt_q;
	logic       stream_end_q;
	sub_idx_t   idx_q;

	logic       can_load;
	logic       load;
	logic       done;
	logic [7:0] nx_byte;
	logic       nx_last;
	logic       nx_bad;
	logic       nx_end;

	assign can_load = !out_valid_q || dout.ready;
	assign load = q_valid && can_load;
	assign q_pop = load && done;

	always_comb begin
		nx_byte = q_entry.data;
		nx_last = 1'b1;
		nx_bad = 1'b0;
		nx_end = q_entry.fin;
		done = 1'b1;
		case (q_entry.kind)
			OP_BYTE: begin
			end
			OP_NUL: begin
				// replacement character, three beats
				case (idx_q)
					IDX_FIRST: begin
						nx_byte = REPL_B0;
						nx_last = 1'b0;
						nx_end = 1'b0;
						done = 1'b0;
					end
					IDX_SECOND: begin
						nx_byte = REPL_B1;
						nx_last = 1'b0;
						nx_end = 1'b0;
						done = 1'b0;
					end
					default: begin
						nx_byte = REPL_B2;
					end
				endcase
			end
			OP_FAULT: begin
				nx_byte = 8'h00;
				nx_bad = 1'b1;
			end
			default: begin
				nx_bad = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= IDX_FIRST;
		end else begin
			if (can_load) begin
				out_valid_q <= q_valid;
			end
			if (load) begin
				case (idx_q)
					IDX_FIRST:  idx_q <= done ? IDX_FIRST : IDX_SECOND;
					IDX_SECOND: idx_q <= done ? IDX_FIRST : IDX_THIRD;
					default:    idx_q <= IDX_FIRST;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= nx_byte;
			run_last_q <= nx_last;
			corrupt_q <= nx_bad;
			stream_end_q <= nx_end;
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.out_byte = out_byte_q;
	assign dout.run_last = run_last_q;
	assign dout.corrupt = corrupt_q;
	assign dout.stream_end = stream_end_q;

	a_mid_nul: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != IDX_FIRST |-> q_valid && q_entry.kind == OP_NUL)
		else $error("expansion index set without a nul entry at the head");

	a_nul_order: assert property (@(posedge clk) disable iff (!arst_n)
		(load && idx_q == IDX_SECOND) |=> idx_q == IDX_THIRD)
		else $error("nul expansion skipped its last beat");

endmodule
`default_nettype wire

// ----- sv/css_input_preprocessor.sv -----
// an accepted byte goes into the entry queue, then into the output register
// throughput: one input byte per cycle unless the queue is full; a nul takes three output beats
// the front stalls only when the entry queue is full, the back only on output backpressure
// an lf after a cr, and bytes after a utf-8 fault that do not end the stream, give no beat
// reset: asynchronous, active low; clears cr, utf-8 and fault state, the queue and the output
`default_nettype none
module css_input_preprocessor import cip_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cip_in_if.sink    din,
	cip_out_if.source dout
);

	logic     q_push;
	logic     q_ready;
	logic     q_pop;
	logic     q_valid;
	q_entry_t wr_entry;
	q_entry_t rd_entry;

	cip_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_entry (wr_entry)
	);

	cip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.wr_ready (q_ready),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_entry (rd_entry)
	);

	cip_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (rd_entry),
		.q_pop   (q_pop),
		.dout    (dout)
	);

endmodule
`default_nettype wire

// ----- test/css_input_preprocessor_tb.sv -----
// testbench for css_input_preprocessor: directed table plus random utf-8 streams
`timescale 1ns / 1ps
module css_input_preprocessor_tb;
	import cip_pkg::*;

	localparam int RANDOM_ITEMS = 400;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       bad;
		logic       fin_end;
	} cip_beat_t;

	typedef enum logic [1:0] {
		EXP_PREDICT,
		EXP_NONE,
		EXP_ONE
	} exp_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		exp_kind_t  kind;
		cip_beat_t  beat;
	} drv_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cip_in_if  din_if();
	cip_out_if dout_if();

	css_input_preprocessor u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	always #6 clk = ~clk;

	// predictor state
	logic       pp_cr;
	logic [2:0] pp_cont;
	logic       pp_failed;

	drv_item_t stim_q[$];
	drv_item_t cur_item;
	cip_beat_t exp_beats[$];
	int        n_errors = 0;
	int        idle_cycles = 0;
	bit        calm = 1'b0;

	function automatic cip_beat_t mk_beat(logic [7:0] d, logic l, logic c, logic e);
		cip_beat_t b;
		b.data    = d;
		b.last    = l;
		b.bad     = c;
		b.fin_end = e;
		return b;
	endfunction

	function automatic drv_item_t row(logic [7:0] d, logic f, exp_kind_t k, cip_beat_t b);
		drv_item_t it;
		it.data = d;
		it.fin  = f;
		it.kind = k;
		it.beat = b;
		return it;
	endfunction

	function automatic int preprocess_byte(input logic [7:0] b, input logic fin,
			output cip_beat_t r [3]);
		int n;
		int ones;
		n = 0;
		ones = 0;
		for (int i = 0; i < 3; i++)
			r[i] = '0;
		if (pp_failed) begin
			if (fin) begin
				r[0] = mk_beat(8'h00, 1'b1, 1'b1, 1'b1);
				pp_cr = 1'b0;
				pp_cont = '0;
				pp_failed = 1'b0;
				n = 1;
			end
			return n;
		end
		if (pp_cont != 3'd0) begin
			pp_cr = 1'b0;
			if (b[7:6] != 2'b10 || (fin && pp_cont > 3'd1)) begin
				r[0] = mk_beat(8'h00, 1'b1, 1'b1, fin);
				pp_failed = 1'b1;
			end else begin
				pp_cont = pp_cont - 3'd1;
				r[0] = mk_beat(b, 1'b1, 1'b0, fin);
			end
			n = 1;
		end else if (b[7]) begin
			while (ones < 8 && b[7 - ones])
				ones++;
			pp_cr = 1'b0;
			if (ones == 1 || fin) begin
				r[0] = mk_beat(8'h00, 1'b1, 1'b1, fin);
				pp_failed = 1'b1;
			end else begin
				pp_cont = 3'(ones - 1);
				r[0] = mk_beat(b, 1'b1, 1'b0, fin);
			end
			n = 1;
		end else if (b == CH_NUL) begin
			pp_cr = 1'b0;
			r[0] = mk_beat(REPL_B0, 1'b0, 1'b0, 1'b0);
			r[1] = mk_beat(REPL_B1, 1'b0, 1'b0, 1'b0);
			r[2] = mk_beat(REPL_B2, 1'b1, 1'b0, fin);
			n = 3;
		end else if (b == CH_CR) begin
			pp_cr = 1'b1;
			r[0] = mk_beat(CH_LF, 1'b1, 1'b0, fin);
			n = 1;
		end else if (b == CH_LF && pp_cr) begin
			pp_cr = 1'b0;
		end else begin
			pp_cr = 1'b0;
			r[0] = mk_beat((b == CH_FF) ? CH_LF : b, 1'b1, 1'b0, fin);
			n = 1;
		end
		if (fin) begin
			pp_cr = 1'b0;
			pp_cont = '0;
			pp_failed = 1'b0;
		end
		return n;
	endfunction

	task automatic flag_error(input string what, input cip_beat_t want, input cip_beat_t got);
		n_errors++;
		if (n_errors <= 10)
			$display({"%s: expected byte %h last %b corrupt %b end %b, ",
				"got byte %h last %b corrupt %b end %b"},
				what, want.data, want.last, want.bad, want.fin_end,
				got.data, got.last, got.bad, got.fin_end);
	endtask

	always @(posedge clk) begin : monitor
		cip_beat_t got;
		cip_beat_t want;
		cip_beat_t pred [3];
		int n;
		if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (din_if.valid && din_if.ready) begin
			n = preprocess_byte(cur_item.data, cur_item.fin, pred);
			case (cur_item.kind)
				EXP_PREDICT: begin
					for (int i = 0; i < n; i++)
						exp_beats.push_back(pred[i]);
				end
				EXP_ONE: exp_beats.push_back(cur_item.beat);
				default: ;
			endcase
		end
		if (dout_if.valid && dout_if.ready) begin
			got = mk_beat(dout_if.out_byte, dout_if.run_last, dout_if.corrupt,
				dout_if.stream_end);
			if (exp_beats.size() == 0) begin
				flag_error("beat with none expected", '0, got);
			end else begin
				want = exp_beats.pop_front();
				if (got !== want)
					flag_error("beat mismatch", want, got);
			end
		end
	end

	// multibyte sequence of n bytes: lead with n ones, then n-1 continuations, or only keep of them if keep is smaller
	task automatic put_seq(ref logic [7:0] bq[$], input int n, input int keep);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = 8'hFF << (8 - n);
		lo = 8'hFF >> (n + 1);
		bq.push_back((n == 8) ? 8'hFF : (hi | (8'($urandom) & lo)));
		for (int i = 1; i < n && i <= keep; i++)
			bq.push_back(8'h80 | 8'($urandom_range(0, 63)));
	endtask

	task automatic put_token(ref logic [7:0] bq[$]);
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			bq.push_back(8'($urandom_range(8'h20, 8'h7E)));
		end else if (r < 48) begin
			bq.push_back(CH_CR);
		end else if (r < 54) begin
			bq.push_back(CH_LF);
		end else if (r < 58) begin
			bq.push_back(CH_CR);
			bq.push_back(CH_LF);
		end else if (r < 62) begin
			bq.push_back(CH_FF);
		end else if (r < 66) begin
			bq.push_back(CH_NUL);
		end else if (r < 72) begin
			bq.push_back(8'($urandom_range(1, 127)));
		end else begin
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) : $urandom_range(2, 4);
			put_seq(bq, n, 8);
		end
	endtask

	task automatic gen_stream();
		logic [7:0] bq[$];
		logic [7:0] bad;
		int kind;
		int fault_kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 8))
				bq.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 10))
				put_token(bq);
			if (kind < 32) begin
				fault_kind = $urandom_range(0, 2);
				n = $urandom_range(2, 8);
				case (fault_kind)
					0: bq.push_back(8'h80 | 8'($urandom_range(0, 63)));
					1: begin
						put_seq(bq, n, $urandom_range(0, n - 2));
						bad = 8'($urandom_range(0, 255));
						if (bad[7:6] == 2'b10)
							bad[6] = 1'b1;
						bq.push_back(bad);
					end
					default: put_seq(bq, n, $urandom_range(0, n - 2));
				endcase
				// trailing bytes after the fault stay silent until the end
				if (fault_kind != 2) begin
					repeat ($urandom_range(0, 4))
						put_token(bq);
				end
			end
		end
		for (int i = 0; i < bq.size(); i++)
			stim_q.push_back(row(bq[i], i == bq.size() - 1, EXP_PREDICT, '0));
	endtask

	task automatic drive_item(input drv_item_t it);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(6, 25);
		repeat (gap) @(negedge clk) din_if.valid <= 1'b0;
		@(negedge clk);
		din_if.valid      <= 1'b1;
		din_if.in_byte    <= it.data;
		din_if.final_byte <= it.fin;
		cur_item          <= it;
		do @(posedge clk); while (!din_if.ready);
	endtask

	initial begin : sink_pacing
		int run;
		int hold;
		int r;
		dout_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
			repeat (run) @(negedge clk) dout_if.ready <= 1'b1;
			r = $urandom_range(0, 99);
			if (r < 70)
				hold = $urandom_range(1, 2);
			else if (r < 95)
				hold = $urandom_range(3, 6);
			else
				hold = $urandom_range(10, 30);
			repeat (hold) @(negedge clk) dout_if.ready <= 1'b0;
		end
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int n_directed;
		din_if.valid      = 1'b0;
		din_if.in_byte    = 8'h00;
		din_if.final_byte = 1'b0;
		cur_item          = '0;
		pp_cr             = 1'b0;
		pp_cont           = '0;
		pp_failed         = 1'b0;

		stim_q.push_back(row(8'h41, 1'b0, EXP_ONE, mk_beat(8'h41, 1'b1, 1'b0, 1'b0)));
		stim_q.push_back(row(CH_NUL, 1'b0, EXP_PREDICT, '0));
		stim_q.push_back(row(CH_CR, 1'b0, EXP_ONE, mk_beat(CH_LF, 1'b1, 1'b0, 1'b0)));
		stim_q.push_back(row(CH_LF, 1'b0, EXP_NONE, '0));
		stim_q.push_back(row(CH_FF, 1'b0, EXP_ONE, mk_beat(CH_LF, 1'b1, 1'b0, 1'b0)));
		stim_q.push_back(row(8'h7F, 1'b0, EXP_ONE, mk_beat(8'h7F, 1'b1, 1'b0, 1'b0)));
		stim_q.push_back(row(8'hC3, 1'b0, EXP_ONE, mk_beat(8'hC3, 1'b1, 1'b0, 1'b0)));
		stim_q.push_back(row(8'hA9, 1'b0, EXP_ONE, mk_beat(8'hA9, 1'b1, 1'b0, 1'b0)));
		// longest sequence, continuations that look like control bytes
		stim_q.push_back(row(8'hFF, 1'b0, EXP_ONE, mk_beat(8'hFF, 1'b1, 1'b0, 1'b0)));
		stim_q.push_back(row(8'h80, 1'b0, EXP_PREDICT, '0));
		stim_q.push_back(row(8'hBF, 1'b0, EXP_PREDICT, '0));
		stim_q.push_back(row(8'h8A, 1'b0, EXP_PREDICT, '0));
		stim_q.push_back(row(8'h8C, 1'b0, EXP_PREDICT, '0));
		stim_q.push_back(row(8'h8D, 1'b0, EXP_PREDICT, '0));
		stim_q.push_back(row(8'h80, 1'b0, EXP_PREDICT, '0));
		stim_q.push_back(row(8'h80, 1'b1, EXP_PREDICT, '0));
		// lone continuation, then silence until the final byte
		stim_q.push_back(row(8'h80, 1'b0, EXP_ONE, mk_beat(8'h00, 1'b1, 1'b1, 1'b0)));
		stim_q.push_back(row(CH_NUL, 1'b1, EXP_ONE, mk_beat(8'h00, 1'b1, 1'b1, 1'b1)));
		// bad continuation
		stim_q.push_back(row(8'hE2, 1'b0, EXP_PREDICT, '0));
		stim_q.push_back(row(8'h41, 1'b0, EXP_ONE, mk_beat(8'h00, 1'b1, 1'b1, 1'b0)));
		stim_q.push_back(row(8'h20, 1'b1, EXP_ONE, mk_beat(8'h00, 1'b1, 1'b1, 1'b1)));
		// cut short by end of stream, on the lead and on a continuation
		stim_q.push_back(row(8'hF0, 1'b1, EXP_ONE, mk_beat(8'h00, 1'b1, 1'b1, 1'b1)));
		stim_q.push_back(row(8'hE0, 1'b0, EXP_PREDICT, '0));
		stim_q.push_back(row(8'hA0, 1'b1, EXP_ONE, mk_beat(8'h00, 1'b1, 1'b1, 1'b1)));
		// dropped final lf gives no stream end
		stim_q.push_back(row(CH_CR, 1'b0, EXP_PREDICT, '0));
		stim_q.push_back(row(CH_LF, 1'b1, EXP_NONE, '0));
		n_directed = stim_q.size();
		while (stim_q.size() < n_directed + RANDOM_ITEMS)
			gen_stream();

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (int i = 0; i < stim_q.size(); i++) begin
			calm = (i % 100) >= 70 && (i % 100) < 95;
			drive_item(stim_q[i]);
		end
		@(negedge clk) din_if.valid <= 1'b0;

		while (exp_beats.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (exp_beats.size() != 0) begin
			n_errors++;
			$display("%0d expected beats never arrived", exp_beats.size());
		end
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
